/* rtl/sme_pkg.sv */
// Shared types and codes for the stack machine executor.
package sme_pkg;

  // Tagged value as held on the stack and in the register file
  typedef struct packed {
    logic [1:0]  tag;
    logic [63:0] val;
  } tval_t;

  localparam logic [1:0] TAG_INT  = 2'd0;
  localparam logic [1:0] TAG_PTR  = 2'd2;
  localparam logic [1:0] TAG_PAIR = 2'd3;

  localparam int unsigned WORD_BYTES = 8;
  localparam logic [7:0]  BYTE_MASK  = 8'hFF;

  typedef enum logic [4:0] {
    OP_NOP      = 5'd0,
    OP_PUSH     = 5'd1,
    OP_PUSH_REG = 5'd2,
    OP_LOAD     = 5'd3,
    OP_POP_REG  = 5'd4,
    OP_STORE    = 5'd5,
    OP_DUP      = 5'd6,
    OP_INC      = 5'd7,
    OP_DEC      = 5'd8,
    OP_ADD      = 5'd9,
    OP_ADD_REG  = 5'd10,
    OP_SUB      = 5'd11,
    OP_SUB_REG  = 5'd12,
    OP_NATIVE   = 5'd13,
    OP_HALT     = 5'd14,
    OP_JMP      = 5'd15,
    OP_JNZ      = 5'd16,
    OP_JZ       = 5'd17
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_JUMP  = 3'd1,
    ST_HALT  = 3'd2,
    ST_OVER  = 3'd3,
    ST_UNDER = 3'd4,
    ST_TYPE  = 3'd5,
    ST_VALUE = 3'd6,
    ST_ADDR  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SECOND,
    S_EXEC
  } state_e;

endpackage

/* rtl/stack_machine_executor.sv */
// Top level: instruction sequencer over stack, register file and heap memories.
//
// Usage: one instruction word enters on the in channel (valid/ready) and one
// result word (status, tag, value) leaves on the out channel (valid/ready).
// Each instruction runs in order through the accept cycle, which issues the first stack,
// register and heap reads, S_SECOND, which reads the next stack entry from the
// single stack read port, and S_EXEC, which executes and writes back.
// A new instruction is taken only in S_IDLE, after the last one has left S_EXEC,
// as the two reads share the one stack read port. Result valid rises when S_EXEC completes.
// A result sits in an output register; the next instruction is accepted
// while it waits, and execution holds in its last cycle if a second result
// would overwrite one not yet taken.
// After reset the heap is swept to zero with in_ready_o
// low; the stack is empty and every register reads int zero.
// Errors leave all state unchanged.
module stack_machine_executor #(
  parameter int STACK_DEPTH    = 256,
  parameter int REGISTER_COUNT = 16,
  parameter int HEAP_BYTES     = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  req_type_i,
  input  logic [1:0]  operand_tag_i,
  input  logic [63:0] operand_value_i,
  input  logic [7:0]  pair_first_i,
  input  logic [7:0]  pair_second_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  value_tag_o,
  output logic [63:0] value_o
);

  localparam int IW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int RIW = $clog2(REGISTER_COUNT);
  localparam int AW  = $clog2(HEAP_BYTES);

  sme_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  sme_pkg::op_e    op_q;
  logic [1:0]      tag_q;
  logic [63:0]     v_q;
  logic            reg_ok_q, addr_ok_q, dup_ok_q, pair_ok_q;
  logic [RIW-1:0]  ra_idx_q;
  sme_pkg::tval_t  a_q;

  logic            out_valid_q;
  sme_pkg::status_e status_q;
  logic [1:0]      otag_q;
  logic [63:0]     oval_q;

  logic            accept, advance, heap_busy, full;
  logic            is_pair;
  logic [RIW-1:0]  ra_idx;

  sme_pkg::tval_t  stk_rdata, ra, rb, stk_wdata, rf_wdata;
  logic            stk_re, stk_we, rf_we, hp_we;
  logic [IW-1:0]   stk_raddr, stk_waddr;
  logic [63:0]     hp_rdata;
  logic [AW-1:0]   hp_addr;

  sme_pkg::status_e res_st;
  logic [1:0]      res_tag;
  logic [63:0]     res_val;

  assign in_ready_o = (state_q == sme_pkg::S_IDLE) && !heap_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign advance    = (state_q == sme_pkg::S_EXEC) && (!out_valid_q || out_ready_i);
  assign full       = (cnt_q == CW'(STACK_DEPTH));
  assign is_pair    = (req_type_i == sme_pkg::OP_ADD_REG) || (req_type_i == sme_pkg::OP_SUB_REG);
  assign ra_idx     = is_pair ? RIW'(pair_first_i) : RIW'(operand_value_i);

  // memory read addresses
  always_comb begin
    stk_re    = 1'b0;
    stk_raddr = IW'(cnt_q - CW'(1));
    if (state_q == sme_pkg::S_SECOND) begin
      stk_re    = 1'b1;
      stk_raddr = IW'(cnt_q - CW'(2));
    end else if (accept) begin
      stk_re = 1'b1;
      if (req_type_i == sme_pkg::OP_DUP) begin
        stk_raddr = IW'(cnt_q) - IW'(1) - IW'(operand_value_i);
      end
    end
  end

  assign hp_addr = (state_q == sme_pkg::S_IDLE) ? AW'(operand_value_i) : AW'(v_q);

  sme_stack_mem #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk_i     (clk_i),
    .rd_en_i   (stk_re),
    .rd_addr_i (stk_raddr),
    .rd_data_o (stk_rdata),
    .wr_en_i   (stk_we),
    .wr_addr_i (stk_waddr),
    .wr_data_i (stk_wdata)
  );

  sme_regfile #(.COUNT(REGISTER_COUNT)) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (ra_idx),
    .rd_addr_b_i (RIW'(pair_second_i)),
    .rd_data_a_o (ra),
    .rd_data_b_o (rb),
    .wr_en_i     (rf_we),
    .wr_addr_i   (ra_idx_q),
    .wr_data_i   (rf_wdata)
  );

  sme_heap #(.HEAP_BYTES(HEAP_BYTES)) u_heap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .addr_i    (hp_addr),
    .rd_en_i   (accept),
    .rd_data_o (hp_rdata),
    .wr_en_i   (hp_we),
    .wr_data_i (a_q.val),
    .busy_o    (heap_busy)
  );

  // instruction latch and operand checks
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= sme_pkg::op_e'(req_type_i);
      tag_q     <= operand_tag_i;
      v_q       <= operand_value_i;
      ra_idx_q  <= ra_idx;
      reg_ok_q  <= (operand_tag_i == sme_pkg::TAG_INT) &&
                   (operand_value_i < 64'(REGISTER_COUNT));
      addr_ok_q <= ((operand_tag_i == sme_pkg::TAG_INT) ||
                    (operand_tag_i == sme_pkg::TAG_PTR)) &&
                   (operand_value_i <= 64'(HEAP_BYTES - sme_pkg::WORD_BYTES));
      dup_ok_q  <= (operand_value_i < 64'(cnt_q));
      pair_ok_q <= (operand_tag_i == sme_pkg::TAG_PAIR) &&
                   (9'(pair_first_i) < 9'(REGISTER_COUNT)) &&
                   (9'(pair_second_i) < 9'(REGISTER_COUNT));
    end
    if (state_q == sme_pkg::S_SECOND) begin
      a_q <= stk_rdata;
    end
    if (advance) begin
      status_q <= res_st;
      otag_q   <= res_tag;
      oval_q   <= res_val;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sme_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sme_pkg::S_IDLE:   if (accept) begin
        state_d = sme_pkg::S_SECOND;
      end
      sme_pkg::S_SECOND: state_d = sme_pkg::S_EXEC;
      sme_pkg::S_EXEC:   if (advance) begin
        state_d = sme_pkg::S_IDLE;
      end
      default:           state_d = sme_pkg::S_IDLE;
    endcase
  end

  // execute: result word and write-back
  always_comb begin
    logic go_stk, go_rf, go_hp;
    go_stk    = 1'b0;
    go_rf     = 1'b0;
    go_hp     = 1'b0;
    res_st    = sme_pkg::ST_OK;
    res_tag   = sme_pkg::TAG_INT;
    res_val   = '0;
    stk_waddr = IW'(cnt_q);
    stk_wdata = a_q;
    rf_wdata  = a_q;
    cnt_d     = cnt_q;
    unique case (op_q)
      sme_pkg::OP_NOP: ;
      sme_pkg::OP_PUSH: begin
        if (full) begin
          res_st = sme_pkg::ST_OVER; res_tag = tag_q; res_val = v_q;
        end else begin
          go_stk = 1'b1; stk_wdata = '{tag: tag_q, val: v_q}; cnt_d = cnt_q + CW'(1);
        end
      end
      sme_pkg::OP_PUSH_REG: begin
        if (!reg_ok_q) begin
          res_st = sme_pkg::ST_VALUE; res_tag = tag_q; res_val = v_q;
        end else if (full) begin
          res_st = sme_pkg::ST_OVER; res_tag = tag_q; res_val = v_q;
        end else begin
          go_stk = 1'b1; stk_wdata = ra; cnt_d = cnt_q + CW'(1);
        end
      end
      sme_pkg::OP_LOAD: begin
        if (!addr_ok_q) begin
          res_st = sme_pkg::ST_ADDR; res_tag = tag_q; res_val = v_q;
        end else if (full) begin
          res_st = sme_pkg::ST_OVER; res_tag = tag_q; res_val = v_q;
        end else begin
          go_stk = 1'b1; stk_wdata = '{tag: sme_pkg::TAG_INT, val: hp_rdata};
          cnt_d = cnt_q + CW'(1);
        end
      end
      sme_pkg::OP_POP_REG: begin
        if (cnt_q == '0) begin
          res_st = sme_pkg::ST_UNDER;
        end else if (!reg_ok_q) begin
          res_st = sme_pkg::ST_VALUE; res_tag = tag_q; res_val = v_q;
        end else begin
          go_rf = 1'b1; cnt_d = cnt_q - CW'(1);
        end
      end
      sme_pkg::OP_STORE: begin
        if (cnt_q == '0) begin
          res_st = sme_pkg::ST_UNDER;
        end else if (!addr_ok_q) begin
          res_st = sme_pkg::ST_ADDR; res_tag = tag_q; res_val = v_q;
        end else begin
          go_hp = 1'b1; cnt_d = cnt_q - CW'(1);
        end
      end
      sme_pkg::OP_DUP: begin
        if (tag_q != sme_pkg::TAG_INT) begin
          res_st = sme_pkg::ST_TYPE; res_tag = tag_q; res_val = v_q;
        end else if (!dup_ok_q) begin
          res_st = sme_pkg::ST_UNDER; res_tag = tag_q; res_val = v_q;
        end else if (full) begin
          res_st = sme_pkg::ST_OVER; res_tag = tag_q; res_val = v_q;
        end else begin
          go_stk = 1'b1; cnt_d = cnt_q + CW'(1);
        end
      end
      sme_pkg::OP_INC, sme_pkg::OP_DEC: begin
        if (!reg_ok_q) begin
          res_st = sme_pkg::ST_VALUE; res_tag = tag_q; res_val = v_q;
        end else if (ra.tag != sme_pkg::TAG_INT) begin
          res_st = sme_pkg::ST_TYPE; res_tag = ra.tag; res_val = ra.val;
        end else begin
          go_rf    = 1'b1;
          rf_wdata = '{tag: sme_pkg::TAG_INT,
                       val: (op_q == sme_pkg::OP_INC) ? ra.val + 64'd1 : ra.val - 64'd1};
        end
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB: begin
        if (cnt_q == '0) begin
          res_st = sme_pkg::ST_UNDER;
        end else if (a_q.tag != sme_pkg::TAG_INT) begin
          res_st = sme_pkg::ST_TYPE; res_tag = a_q.tag; res_val = a_q.val;
        end else if (cnt_q < CW'(2)) begin
          res_st = sme_pkg::ST_UNDER;
        end else if (stk_rdata.tag != sme_pkg::TAG_INT) begin
          res_st = sme_pkg::ST_TYPE; res_tag = stk_rdata.tag; res_val = stk_rdata.val;
        end else begin
          go_stk    = 1'b1;
          stk_waddr = IW'(cnt_q - CW'(2));
          stk_wdata = '{tag: sme_pkg::TAG_INT,
                        val: (op_q == sme_pkg::OP_ADD) ? stk_rdata.val + a_q.val
                                                       : stk_rdata.val - a_q.val};
          cnt_d     = cnt_q - CW'(1);
        end
      end
      sme_pkg::OP_ADD_REG, sme_pkg::OP_SUB_REG: begin
        if (!pair_ok_q) begin
          res_st = sme_pkg::ST_VALUE; res_tag = tag_q; res_val = v_q;
        end else if (ra.tag != sme_pkg::TAG_INT) begin
          res_st = sme_pkg::ST_TYPE; res_tag = ra.tag; res_val = ra.val;
        end else if (rb.tag != sme_pkg::TAG_INT) begin
          res_st = sme_pkg::ST_TYPE; res_tag = rb.tag; res_val = rb.val;
        end else begin
          go_rf    = 1'b1;
          rf_wdata = '{tag: sme_pkg::TAG_INT,
                       val: (op_q == sme_pkg::OP_ADD_REG) ? ra.val + rb.val : ra.val - rb.val};
        end
      end
      sme_pkg::OP_HALT: begin
        if (cnt_q == '0) begin
          res_st = sme_pkg::ST_UNDER;
        end else begin
          cnt_d = cnt_q - CW'(1);
          res_st = sme_pkg::ST_HALT; res_tag = a_q.tag; res_val = a_q.val;
        end
      end
      sme_pkg::OP_JMP: begin
        res_st = sme_pkg::ST_JUMP; res_tag = tag_q; res_val = v_q;
      end
      sme_pkg::OP_JNZ, sme_pkg::OP_JZ: begin
        if (cnt_q == '0) begin
          res_st = sme_pkg::ST_UNDER;
        end else if (a_q.tag != sme_pkg::TAG_INT) begin
          res_st = sme_pkg::ST_TYPE; res_tag = a_q.tag; res_val = a_q.val;
        end else begin
          cnt_d = cnt_q - CW'(1);
          if ((op_q == sme_pkg::OP_JNZ) == (a_q.val != '0)) begin
            res_st = sme_pkg::ST_JUMP; res_tag = tag_q; res_val = v_q;
          end
        end
      end
      default: begin
        res_st = sme_pkg::ST_VALUE; res_val = 64'(op_q);
      end
    endcase
    stk_we = advance && go_stk;
    rf_we  = advance && go_rf;
    hp_we  = advance && go_hp;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_tag_o = otag_q;
  assign value_o     = oval_q;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_busy |-> !in_ready_o) else $error("input taken during heap clear");
  a_accept_to_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == sme_pkg::S_SECOND)) else $error("sequencer skipped read");
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o) else $error("result lost");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH)) else $error("stack count past depth");
`endif

endmodule

/* rtl/sme_stack_mem.sv */
// Value stack memory: one write port, one registered read port.
module sme_stack_mem #(
  parameter int DEPTH = 256,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IW-1:0]     rd_addr_i,
  output sme_pkg::tval_t    rd_data_o,
  input  logic              wr_en_i,
  input  logic [IW-1:0]     wr_addr_i,
  input  sme_pkg::tval_t    wr_data_i
);

  sme_pkg::tval_t mem [DEPTH];
  sme_pkg::tval_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/sme_regfile.sv */
// Register file memory: two registered read ports, one write port, valid bits.
module sme_regfile #(
  parameter int COUNT = 16,
  localparam int RIW = $clog2(COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [RIW-1:0]    rd_addr_a_i,
  input  logic [RIW-1:0]    rd_addr_b_i,
  output sme_pkg::tval_t    rd_data_a_o,
  output sme_pkg::tval_t    rd_data_b_o,
  input  logic              wr_en_i,
  input  logic [RIW-1:0]    wr_addr_i,
  input  sme_pkg::tval_t    wr_data_i
);

  sme_pkg::tval_t mem [COUNT];
  logic [COUNT-1:0] valid_q;
  sme_pkg::tval_t rd_a_q, rd_b_q;
  logic va_q, vb_q;

  // valid bits: unwritten entries read as int zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        va_q <= valid_q[rd_addr_a_i];
        vb_q <= valid_q[rd_addr_b_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = va_q ? rd_a_q : '0;
  assign rd_data_b_o = vb_q ? rd_b_q : '0;

endmodule

/* rtl/sme_heap.sv */
// Byte heap in eight byte banks, unaligned 64-bit little-endian access, clear after reset.
module sme_heap #(
  parameter int HEAP_BYTES = 65536,
  localparam int AW   = $clog2(HEAP_BYTES),
  localparam int ROWS = (HEAP_BYTES + 7) / 8,
  localparam int RW   = $clog2(ROWS),
  localparam int CRW  = $clog2(ROWS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] addr_i,
  input  logic          rd_en_i,
  output logic [63:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [63:0]   wr_data_i,
  output logic          busy_o
);

  logic [CRW-1:0] clr_q;
  logic [2:0]     lo_q;
  logic [7:0]     rbyte [8];
  logic [2:0]     lo;

  assign lo     = addr_i[2:0];
  assign busy_o = (clr_q != CRW'(ROWS));

  // clearing sweep, one row of all banks per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_q + CRW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      lo_q <= lo;
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [7:0]    rd_q;
    logic [RW-1:0] row;
    logic [2:0]    bi;
    logic [7:0]    wbyte;

    // bank k holds byte (k - lo) of the word, one row up when k is below lo
    assign bi    = 3'(k) - lo;
    assign row   = RW'(addr_i >> 3) + RW'(3'(k) < lo);
    assign wbyte = 8'(wr_data_i >> {bi, 3'b000}) & sme_pkg::BYTE_MASK;

    always_ff @(posedge clk_i) begin
      if (busy_o) begin
        mem[clr_q[RW-1:0]] <= '0;
      end else if (wr_en_i) begin
        mem[row] <= wbyte;
      end
      if (rd_en_i) begin
        rd_q <= mem[row];
      end
    end

    assign rbyte[k] = rd_q;
  end

  // gather bytes back into word order
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rd_data_o[8*i +: 8] = rbyte[3'(lo_q + 3'(i))];
    end
  end

endmodule

/* bench/tb_stack_machine_executor.sv */
// Self-checking testbench for the stack machine executor.
`timescale 1ns / 100ps

module tb_stack_machine_executor;

  localparam int DEPTH = 256;
  localparam int NREG = 16;
  localparam int HBYTES = 65536;
  localparam int NRAND = 730;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [4:0]  req_type_i = '0;
  logic [1:0]  operand_tag_i = '0;
  logic [63:0] operand_value_i = '0;
  logic [7:0]  pair_first_i = '0;
  logic [7:0]  pair_second_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [1:0]  value_tag_o;
  logic [63:0] value_o;

  stack_machine_executor dut (.*);

  always #2 clk_i = ~clk_i;

  // Result word: status, tag, value
  typedef struct packed {
    logic [2:0]  st;
    logic [1:0]  tag;
    logic [63:0] val;
  } result_t;

  typedef struct packed {
    logic [4:0]  op;
    logic [1:0]  tag;
    logic [63:0] val;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic        chk;  // typed-in expectation present
    result_t     res;
  } instr_t;

  // Predictor state
  sme_pkg::tval_t stk[DEPTH];
  int             sp;
  sme_pkg::tval_t regs[NREG];
  logic [7:0]     heap[HBYTES];

  result_t pending_q[$];
  int      errors = 0;
  int      n_done = 0;
  int      n_jump = 0;
  int      n_err = 0;
  bit      stim_done = 0;

  function automatic result_t mk(sme_pkg::status_e s, logic [1:0] t, logic [63:0] v);
    result_t r;
    r.st = s; r.tag = t; r.val = v;
    return r;
  endfunction

  function automatic bit addr_good(logic [1:0] t, logic [63:0] v);
    return (t == sme_pkg::TAG_INT || t == sme_pkg::TAG_PTR) &&
           v <= 64'(HBYTES - sme_pkg::WORD_BYTES);
  endfunction

  // Execute one instruction on the shadow machine
  function automatic result_t execute(instr_t w);
    sme_pkg::tval_t a, b;
    logic [63:0] r;
    bit full;
    full = sp >= DEPTH;
    case (w.op)
      sme_pkg::OP_NOP: return mk(sme_pkg::ST_OK, 0, 0);
      sme_pkg::OP_PUSH: begin
        if (full) return mk(sme_pkg::ST_OVER, w.tag, w.val);
        stk[sp] = {w.tag, w.val}; sp++;
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_PUSH_REG: begin
        if (!(w.tag == sme_pkg::TAG_INT && w.val < NREG))
          return mk(sme_pkg::ST_VALUE, w.tag, w.val);
        if (full) return mk(sme_pkg::ST_OVER, w.tag, w.val);
        stk[sp] = regs[w.val]; sp++;
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_LOAD: begin
        if (!addr_good(w.tag, w.val)) return mk(sme_pkg::ST_ADDR, w.tag, w.val);
        if (full) return mk(sme_pkg::ST_OVER, w.tag, w.val);
        for (int i = 0; i < sme_pkg::WORD_BYTES; i++) r[8*i +: 8] = heap[w.val + i];
        stk[sp] = {sme_pkg::TAG_INT, r}; sp++;
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_POP_REG: begin
        if (sp == 0) return mk(sme_pkg::ST_UNDER, 0, 0);
        if (!(w.tag == sme_pkg::TAG_INT && w.val < NREG))
          return mk(sme_pkg::ST_VALUE, w.tag, w.val);
        sp--; regs[w.val] = stk[sp];
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_STORE: begin
        if (sp == 0) return mk(sme_pkg::ST_UNDER, 0, 0);
        if (!addr_good(w.tag, w.val)) return mk(sme_pkg::ST_ADDR, w.tag, w.val);
        sp--;
        for (int i = 0; i < sme_pkg::WORD_BYTES; i++) heap[w.val + i] = stk[sp].val[8*i +: 8];
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_DUP: begin
        if (w.tag != sme_pkg::TAG_INT) return mk(sme_pkg::ST_TYPE, w.tag, w.val);
        if (w.val >= 64'(sp)) return mk(sme_pkg::ST_UNDER, w.tag, w.val);
        if (full) return mk(sme_pkg::ST_OVER, w.tag, w.val);
        stk[sp] = stk[sp - 1 - int'(w.val)]; sp++;
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_INC, sme_pkg::OP_DEC: begin
        if (!(w.tag == sme_pkg::TAG_INT && w.val < NREG))
          return mk(sme_pkg::ST_VALUE, w.tag, w.val);
        a = regs[w.val];
        if (a.tag != sme_pkg::TAG_INT) return mk(sme_pkg::ST_TYPE, a.tag, a.val);
        regs[w.val].val = (w.op == sme_pkg::OP_INC) ? a.val + 1 : a.val - 1;
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB: begin
        if (sp == 0) return mk(sme_pkg::ST_UNDER, 0, 0);
        a = stk[sp - 1];
        if (a.tag != sme_pkg::TAG_INT) return mk(sme_pkg::ST_TYPE, a.tag, a.val);
        if (sp < 2) return mk(sme_pkg::ST_UNDER, 0, 0);
        b = stk[sp - 2];
        if (b.tag != sme_pkg::TAG_INT) return mk(sme_pkg::ST_TYPE, b.tag, b.val);
        sp -= 2;
        stk[sp] = {sme_pkg::TAG_INT, (w.op == sme_pkg::OP_ADD) ? b.val + a.val : b.val - a.val};
        sp++;
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_ADD_REG, sme_pkg::OP_SUB_REG: begin
        if (w.tag != sme_pkg::TAG_PAIR || w.p1 >= NREG || w.p2 >= NREG)
          return mk(sme_pkg::ST_VALUE, w.tag, w.val);
        a = regs[w.p1]; b = regs[w.p2];
        if (a.tag != sme_pkg::TAG_INT) return mk(sme_pkg::ST_TYPE, a.tag, a.val);
        if (b.tag != sme_pkg::TAG_INT) return mk(sme_pkg::ST_TYPE, b.tag, b.val);
        regs[w.p1].val = (w.op == sme_pkg::OP_ADD_REG) ? a.val + b.val : a.val - b.val;
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      sme_pkg::OP_HALT: begin
        if (sp == 0) return mk(sme_pkg::ST_UNDER, 0, 0);
        sp--;
        return mk(sme_pkg::ST_HALT, stk[sp].tag, stk[sp].val);
      end
      sme_pkg::OP_JMP: return mk(sme_pkg::ST_JUMP, w.tag, w.val);
      sme_pkg::OP_JNZ, sme_pkg::OP_JZ: begin
        if (sp == 0) return mk(sme_pkg::ST_UNDER, 0, 0);
        a = stk[sp - 1];
        if (a.tag != sme_pkg::TAG_INT) return mk(sme_pkg::ST_TYPE, a.tag, a.val);
        sp--;
        if ((w.op == sme_pkg::OP_JNZ) == (a.val != 0)) return mk(sme_pkg::ST_JUMP, w.tag, w.val);
        return mk(sme_pkg::ST_OK, 0, 0);
      end
      default: return mk(sme_pkg::ST_VALUE, sme_pkg::TAG_INT, 64'(w.op));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %0s: got %h expected %h (result %0d)", what, got, want, n_done);
    errors++;
  endtask

  function automatic instr_t row(sme_pkg::op_e op, logic [1:0] t, logic [63:0] v,
                                 logic [7:0] p1 = 0, logic [7:0] p2 = 0,
                                 bit chk = 0, result_t res = '0);
    instr_t w;
    w.op = op; w.tag = t; w.val = v; w.p1 = p1; w.p2 = p2; w.chk = chk; w.res = res;
    return w;
  endfunction

  // Directed table: typed results where obvious, predictor elsewhere
  instr_t dir_tbl[$];

  initial begin
    dir_tbl = '{
      row(sme_pkg::OP_POP_REG, sme_pkg::TAG_INT, 0, 0, 0, 1, mk(sme_pkg::ST_UNDER, 0, 0)),
      row(sme_pkg::OP_HALT, sme_pkg::TAG_INT, 0, 0, 0, 1, mk(sme_pkg::ST_UNDER, 0, 0)),
      row(sme_pkg::OP_ADD, sme_pkg::TAG_INT, 0, 0, 0, 1, mk(sme_pkg::ST_UNDER, 0, 0)),
      row(sme_pkg::OP_NATIVE, sme_pkg::TAG_INT, 5, 0, 0, 1,
          mk(sme_pkg::ST_VALUE, sme_pkg::TAG_INT, 13)),
      row(sme_pkg::op_e'(5'd31), sme_pkg::TAG_PTR, 1, 0, 0, 1,
          mk(sme_pkg::ST_VALUE, sme_pkg::TAG_INT, 31)),
      row(sme_pkg::OP_NOP, sme_pkg::TAG_PAIR, '1, 8'hFF, 8'hFF, 1, mk(sme_pkg::ST_OK, 0, 0)),
      row(sme_pkg::OP_JMP, sme_pkg::TAG_PAIR, 64'h8000_0000_0000_0000, 0, 0, 1,
          mk(sme_pkg::ST_JUMP, sme_pkg::TAG_PAIR, 64'h8000_0000_0000_0000)),
      row(sme_pkg::OP_PUSH, sme_pkg::TAG_INT, 64'h7FFF_FFFF_FFFF_FFFF),
      row(sme_pkg::OP_PUSH, sme_pkg::TAG_INT, 1),
      row(sme_pkg::OP_ADD, sme_pkg::TAG_INT, 0),
      row(sme_pkg::OP_STORE, sme_pkg::TAG_PTR, HBYTES - 8),
      row(sme_pkg::OP_LOAD, sme_pkg::TAG_INT, HBYTES - 7, 0, 0, 1,
          mk(sme_pkg::ST_ADDR, sme_pkg::TAG_INT, HBYTES - 7)),
      row(sme_pkg::OP_LOAD, sme_pkg::TAG_PTR, HBYTES - 8),
      row(sme_pkg::OP_LOAD, 2'd1, 0, 0, 0, 1, mk(sme_pkg::ST_ADDR, 2'd1, 0)),
      row(sme_pkg::OP_DUP, 2'd1, 0, 0, 0, 1, mk(sme_pkg::ST_TYPE, 2'd1, 0)),
      row(sme_pkg::OP_DUP, sme_pkg::TAG_INT, '1, 0, 0, 1,
          mk(sme_pkg::ST_UNDER, sme_pkg::TAG_INT, '1)),
      row(sme_pkg::OP_DUP, sme_pkg::TAG_INT, 0),
      row(sme_pkg::OP_POP_REG, sme_pkg::TAG_INT, NREG, 0, 0, 1,
          mk(sme_pkg::ST_VALUE, sme_pkg::TAG_INT, NREG)),
      row(sme_pkg::OP_POP_REG, sme_pkg::TAG_INT, NREG - 1),
      row(sme_pkg::OP_INC, sme_pkg::TAG_INT, NREG - 1),
      row(sme_pkg::OP_DEC, sme_pkg::TAG_INT, 3),
      row(sme_pkg::OP_PUSH, sme_pkg::TAG_PTR, 7),
      row(sme_pkg::OP_POP_REG, sme_pkg::TAG_INT, 2),
      row(sme_pkg::OP_INC, sme_pkg::TAG_INT, 2, 0, 0, 1,
          mk(sme_pkg::ST_TYPE, sme_pkg::TAG_PTR, 7)),
      row(sme_pkg::OP_ADD_REG, sme_pkg::TAG_PAIR, 0, 15, 3),
      row(sme_pkg::OP_SUB_REG, sme_pkg::TAG_PAIR, 0, 16, 0, 1,
          mk(sme_pkg::ST_VALUE, sme_pkg::TAG_PAIR, 0)),
      row(sme_pkg::OP_PUSH, sme_pkg::TAG_INT, 0),
      row(sme_pkg::OP_JZ, sme_pkg::TAG_INT, 99, 0, 0, 1,
          mk(sme_pkg::ST_JUMP, sme_pkg::TAG_INT, 99)),
      row(sme_pkg::OP_PUSH, 2'd1, 3),
      row(sme_pkg::OP_SUB, sme_pkg::TAG_INT, 0, 0, 0, 1, mk(sme_pkg::ST_TYPE, 2'd1, 3)),
      row(sme_pkg::OP_HALT, sme_pkg::TAG_INT, 0, 0, 0, 1, mk(sme_pkg::ST_HALT, 2'd1, 3))
    };
  end

  // Random instruction: mostly well-formed operands, some noise
  function automatic instr_t rand_instr(int fill_bias);
    instr_t w;
    int k;
    w = '0;
    k = $urandom_range(0, 99);
    if (k < 3) w.op = 5'($urandom_range(18, 31));
    else if (k < fill_bias) w.op = (k & 3) ? sme_pkg::OP_PUSH : sme_pkg::OP_DUP;
    else w.op = 5'($urandom_range(0, 17));
    w.tag = ($urandom_range(0, 5) == 0) ? 2'($urandom) : sme_pkg::TAG_INT;
    case ($urandom_range(0, 4))
      0: w.val = {$urandom, $urandom};
      1: w.val = 64'($urandom_range(0, 20));
      2: w.val = 64'($urandom_range(0, 15)) * 8;
      3: w.val = 64'(HBYTES - $urandom_range(1, 16));
      default: w.val = 64'($urandom_range(0, NREG - 1));
    endcase
    if (w.op == sme_pkg::OP_PUSH && $urandom_range(0, 1)) w.val = {$urandom, $urandom};
    if ((w.op == sme_pkg::OP_LOAD || w.op == sme_pkg::OP_STORE) && $urandom_range(0, 3) == 0)
      w.tag = sme_pkg::TAG_PTR;
    if (w.op == sme_pkg::OP_ADD_REG || w.op == sme_pkg::OP_SUB_REG) begin
      if ($urandom_range(0, 5) != 0) w.tag = sme_pkg::TAG_PAIR;
      w.p1 = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, NREG - 1));
      w.p2 = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, NREG - 1));
    end else begin
      w.p1 = 8'($urandom); w.p2 = 8'($urandom);
    end
    return w;
  endfunction

  // Hand one word to the block and queue its expectation
  task automatic send(instr_t w);
    result_t r;
    req_type_i <= w.op; operand_tag_i <= w.tag; operand_value_i <= w.val;
    pair_first_i <= w.p1; pair_second_i <= w.p2; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    r = execute(w);
    if (w.chk && r !== w.res) report_mismatch("table vs predictor", r.val, w.res.val);
    pending_q = {pending_q, r};
  endtask

  // Stimulus
  initial begin
    int gap, burst, bias;
    sp = 0;
    for (int i = 0; i < NREG; i++) regs[i] = {sme_pkg::TAG_INT, 64'd0};
    for (int i = 0; i < HBYTES; i++) heap[i] = 8'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    #0;
    foreach (dir_tbl[i]) send(dir_tbl[i]);
    in_valid_i <= 1'b0;
    // Hold off until the block has drained
    while (pending_q.size() != 0) @(posedge clk_i);
    burst = 0;
    for (int n = 0; n < NRAND; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst--;
      // Long push-heavy phase runs the stack into overflow, mixed ops drain it after
      bias = (n >= 150 && n < 550) ? 90 : 15;
      send(rand_instr(bias));
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // Receiver stall pattern
  initial begin
    int ph;
    ph = 0;
    forever begin
      @(posedge clk_i);
      ph++;
      if ((ph / 200) % 4 == 3) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0) && (ph % 7 != 0);
    end
  end

  // Result checking
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result word", value_o, 64'd0);
      end else begin
        w = pending_q.pop_front();
        if (status_o !== w.st) report_mismatch("status", 64'(status_o), 64'(w.st));
        if (value_tag_o !== w.tag) report_mismatch("value_tag", 64'(value_tag_o), 64'(w.tag));
        if (value_o !== w.val) report_mismatch("value", value_o, w.val);
        if (w.st == sme_pkg::ST_JUMP) n_jump++;
        else if (w.st != sme_pkg::ST_OK && w.st != sme_pkg::ST_HALT) n_err++;
      end
      n_done++;
    end
  end

  // Completion
  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Checked %0d result words: %0d jumps, %0d error statuses.", n_done, n_jump, n_err);
    $display("Covered every opcode, stack fill to overflow, heap bounds and pair ops.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("stack_machine_executor test passed");
    end else begin
      $display("stack_machine_executor test failed");
    end
    $finish;
  end

  // Timeout; allows for the heap clear after reset
  initial begin
    #2000000;
    $display("stack_machine_executor test failed");
    $finish;
  end

endmodule
